// ===== hw/rtl/load_cell_tare_and_scale_defines.svh =====
// Assertion macros for the load cell tare and scale RTL.
`ifndef LOAD_CELL_TARE_AND_SCALE_DEFINES_SVH
`define LOAD_CELL_TARE_AND_SCALE_DEFINES_SVH

// Checked on every clock edge outside reset; expects clk and arst_n in scope.
`define LCTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included; expects clk in scope.
`define LCTS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lcts_pkg.sv =====
// Shared widths, codes and pipeline types of the load cell tare and scale block.
`default_nettype none

package lcts_pkg;

	localparam int RAW_W            = 24;
	localparam int WT_W             = 32;
	localparam int UPC_W            = 32;
	localparam int FRAC_SHIFT       = 16;
	localparam int DEF_TARE_SAMPLES = 16;

	localparam logic [UPC_W-1:0] UPC_RESET = 32'h0100_0000;

	typedef enum logic {
		OP_SAMPLE  = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	// One sample moving down the pipeline.
	typedef struct packed {
		logic                    vld;
		logic                    done;
		logic                    neg;
		logic                    tared;
		logic signed [RAW_W-1:0] raw;
	} item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcts_tare.sv =====
// Tare accumulator: sample count, running sum and tare flag, plus the first stage.
`default_nettype none

`include "load_cell_tare_and_scale_defines.svh"

module lcts_tare #(
	parameter int TARE_SAMPLES = lcts_pkg::DEF_TARE_SAMPLES,
	localparam int SUM_W = lcts_pkg::RAW_W + $clog2(TARE_SAMPLES)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           accept,
	input  wire logic                           operation,
	input  wire logic signed [lcts_pkg::RAW_W-1:0] raw_sample,
	output lcts_pkg::item_t                     item_s1,
	output logic [SUM_W-1:0]                    sum_mag_s1
);
	import lcts_pkg::*;

	localparam int CNT_W = $clog2(TARE_SAMPLES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TARE_SAMPLES - 1);

	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_nxt;
	logic                    tared_q;
	logic                    is_sample;
	logic                    is_restart;
	logic                    block_end;

	assign is_sample  = accept && (operation == OP_SAMPLE);
	assign is_restart = accept && (operation == OP_RESTART);
	assign sum_nxt    = sum_q + SUM_W'(raw_sample);
	assign block_end  = is_sample && !tared_q && (count_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			tared_q <= 1'b0;
		end else if (is_restart) begin
			// keep a partial block; only the flag drops
			tared_q <= 1'b0;
		end else if (is_sample && !tared_q) begin
			if (block_end) begin
				count_q <= '0;
				sum_q   <= '0;
				tared_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1.vld   <= is_sample;
			item_s1.done  <= block_end;
			item_s1.neg   <= sum_nxt[SUM_W-1];
			item_s1.tared <= block_end || tared_q;
			item_s1.raw   <= raw_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_mag_s1 <= sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
		end
	end

	`LCTS_ASSERT_ALWAYS(a_tared_idle_acc, tared_q |-> (count_q == '0 && sum_q == '0), "accumulator not clear while tared")
	`LCTS_ASSERT(a_done_is_tared, (item_s1.vld && item_s1.done) |-> item_s1.tared, "block end without tare flag")
	`LCTS_ASSERT(a_flag_drop, $fell(tared_q) |-> $past(is_restart), "tare flag dropped without restart")

endmodule

`default_nettype wire

// ===== hw/rtl/lcts_avg.sv =====
// Block average: divide the sum by the block size and hold the zero offset.
`default_nettype none

module lcts_avg #(
	parameter int TARE_SAMPLES = lcts_pkg::DEF_TARE_SAMPLES,
	localparam int SUM_W = lcts_pkg::RAW_W + $clog2(TARE_SAMPLES)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire lcts_pkg::item_t                    item_s1,
	input  wire logic [SUM_W-1:0]                   sum_mag_s1,
	output lcts_pkg::item_t                         item_s3,
	output logic signed [lcts_pkg::RAW_W-1:0]       offset
);
	import lcts_pkg::*;

	// floor(2^SUM_W / N) undershoots the quotient by at most one
	localparam logic [SUM_W-1:0] RECIP =
		SUM_W'((longint'(1) << SUM_W) / TARE_SAMPLES);
	localparam logic [SUM_W:0] DIVISOR = (SUM_W + 1)'(TARE_SAMPLES);

	item_t                   item_s2;
	logic [SUM_W-1:0]        sum_mag_s2;
	logic [SUM_W-1:0]        q_est_s2;
	logic [2*SUM_W-1:0]      prod;
	logic [SUM_W:0]          q_times_n;
	logic [SUM_W:0]          rem;
	logic [SUM_W-1:0]        q_fix;
	logic [RAW_W-1:0]        off_mag;
	logic signed [RAW_W-1:0] off_nxt;
	logic signed [RAW_W-1:0] offset_q;

	assign prod = (2 * SUM_W)'(sum_mag_s1) * (2 * SUM_W)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
			item_s3 <= '0;
		end else if (adv) begin
			item_s2 <= item_s1;
			item_s3 <= item_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_mag_s2 <= sum_mag_s1;
			q_est_s2   <= prod[2*SUM_W-1:SUM_W];
		end
	end

	// one correction step brings the estimate to the floor
	assign q_times_n = {1'b0, q_est_s2} * DIVISOR;
	assign rem       = {1'b0, sum_mag_s2} - q_times_n;
	assign q_fix     = (rem >= DIVISOR) ? q_est_s2 + 1'b1 : q_est_s2;
	assign off_mag   = q_fix[RAW_W-1:0];
	assign off_nxt   = item_s2.neg ? -$signed(off_mag) : $signed(off_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (adv && item_s2.vld && item_s2.done) begin
			offset_q <= off_nxt;
		end
	end

	assign offset = offset_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lcts_scale.sv =====
// Scaling: offset subtract, multiply by units per count, round, saturate, result register.
`default_nettype none

module lcts_scale (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               adv,
	input  wire lcts_pkg::item_t                    item_s3,
	input  wire logic signed [lcts_pkg::RAW_W-1:0]  offset,
	input  wire logic [lcts_pkg::UPC_W-1:0]         upc,
	output logic                                    result_valid,
	output logic signed [lcts_pkg::RAW_W-1:0]       raw_value,
	output logic                                    is_tared,
	output logic signed [lcts_pkg::WT_W-1:0]        weight_units
);
	import lcts_pkg::*;

	localparam int DIFF_W = RAW_W + 1;
	localparam int PROD_W = DIFF_W + UPC_W;
	localparam int RND_W  = PROD_W + 1;
	localparam int Q_W    = RND_W - FRAC_SHIFT;

	localparam logic [Q_W-1:0]  POS_LIMIT = Q_W'((longint'(1) << (WT_W - 1)) - 1);
	localparam logic [Q_W-1:0]  NEG_LIMIT = Q_W'(longint'(1) << (WT_W - 1));
	localparam logic [RND_W-1:0] HALF     = RND_W'(longint'(1) << (FRAC_SHIFT - 1));
	localparam logic [WT_W-1:0] WT_MAX    = {1'b0, {(WT_W - 1){1'b1}}};
	localparam logic [WT_W-1:0] WT_MIN    = {1'b1, {(WT_W - 1){1'b0}}};

	item_t                    item_s4;
	item_t                    item_s5;
	logic                     neg_s4;
	logic                     neg_s5;
	logic [DIFF_W-1:0]        mag_s4;
	logic [PROD_W-1:0]        prod_s5;
	logic signed [DIFF_W-1:0] diff;
	logic [RND_W-1:0]         rnd;
	logic [Q_W-1:0]           q;
	logic [WT_W-1:0]          wt_nxt;
	logic                     result_valid_q;

	assign diff = DIFF_W'(item_s3.raw) - DIFF_W'(offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s4        <= '0;
			item_s5        <= '0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			item_s4        <= item_s3;
			item_s5        <= item_s4;
			result_valid_q <= item_s5.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s4  <= diff[DIFF_W-1];
			mag_s4  <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
			neg_s5  <= neg_s4;
			prod_s5 <= PROD_W'(mag_s4) * PROD_W'(upc);
		end
	end

	// round half away from zero on the magnitude, then sign and clamp
	assign rnd = RND_W'(prod_s5) + HALF;
	assign q   = rnd[RND_W-1:FRAC_SHIFT];

	always_comb begin
		if (neg_s5) begin
			wt_nxt = (q > NEG_LIMIT) ? WT_MIN : WT_W'(-q);
		end else begin
			wt_nxt = (q > POS_LIMIT) ? WT_MAX : q[WT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raw_value    <= item_s5.raw;
			is_tared     <= item_s5.tared;
			weight_units <= $signed(wt_nxt);
		end
	end

	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/load_cell_tare_and_scale.sv =====
// Load cell tare averaging and calibrated weight scaling, top level.
//
// Input channel: sample_valid / sample_stall with operation and raw_sample.
// An item is taken on a clock edge with sample_valid high and sample_stall
// low. A sample item yields one result; a restart item clears the tare flag
// and yields nothing.
// Output channel: result_valid / result_stall with raw_value, is_tared and
// weight_units (signed Q23.8, clamped at the 32-bit limits).
// Throughput is one item per cycle while result_stall does not hold the
// pipeline: the tare sum is registered in the first stage, the block average
// goes through a reciprocal multiply and correction over two stages, and the
// weight through subtract, multiply and round over three more.
// While result_valid is high and result_stall is high the whole pipeline
// holds and sample_stall rises; the waiting result stays unchanged.
// cfg_wr_en / cfg_wr_data write units_per_count (unsigned Q8.24); write it
// only while the pipeline is empty.
// After reset: not tared, offset zero, units_per_count 1.0, no result pending.
`default_nettype none

module load_cell_tare_and_scale #(
	parameter int TARE_SAMPLES = lcts_pkg::DEF_TARE_SAMPLES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               sample_valid,
	output logic                                    sample_stall,
	input  wire logic                               operation,
	input  wire logic signed [lcts_pkg::RAW_W-1:0]  raw_sample,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic signed [lcts_pkg::RAW_W-1:0]       raw_value,
	output logic                                    is_tared,
	output logic signed [lcts_pkg::WT_W-1:0]        weight_units,
	input  wire logic                               cfg_wr_en,
	input  wire logic [lcts_pkg::UPC_W-1:0]         cfg_wr_data
);
	import lcts_pkg::*;

	localparam int SUM_W = RAW_W + $clog2(TARE_SAMPLES);

	logic                    adv;
	logic                    accept;
	logic [UPC_W-1:0]        upc_q;
	item_t                   item_s1;
	item_t                   item_s3;
	logic [SUM_W-1:0]        sum_mag_s1;
	logic signed [RAW_W-1:0] offset;

	// advance everything unless the result register is full and held
	assign adv          = !(result_valid && result_stall);
	assign sample_stall = !adv;
	assign accept       = sample_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_RESET;
		end else if (cfg_wr_en) begin
			upc_q <= cfg_wr_data;
		end
	end

	lcts_tare #(
		.TARE_SAMPLES (TARE_SAMPLES)
	) u_tare (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.accept     (accept),
		.operation  (operation),
		.raw_sample (raw_sample),
		.item_s1    (item_s1),
		.sum_mag_s1 (sum_mag_s1)
	);

	lcts_avg #(
		.TARE_SAMPLES (TARE_SAMPLES)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_s1    (item_s1),
		.sum_mag_s1 (sum_mag_s1),
		.item_s3    (item_s3),
		.offset     (offset)
	);

	lcts_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.item_s3      (item_s3),
		.offset       (offset),
		.upc          (upc_q),
		.result_valid (result_valid),
		.raw_value    (raw_value),
		.is_tared     (is_tared),
		.weight_units (weight_units)
	);

endmodule

`default_nettype wire
